// File: hw/rtl/lfps_pkg.sv
// Shared widths, weights, register indexes and types of the line-follow PID steering block.
`timescale 1ns / 1ps

package lfps_pkg;

    localparam int SENSOR_COUNT   = 8;
    localparam int THR_BITS       = 10;
    localparam int GAIN_BITS      = 16;
    localparam int SPEED_BITS     = 12;
    localparam int ERR_BITS       = 6;
    localparam int DERR_BITS      = 7;
    localparam int INTEG_BITS     = 24;
    localparam int IPROD_BITS     = 23;
    localparam int PPROD_BITS     = 23;
    localparam int DPROD_BITS     = 24;
    localparam int SUM_BITS       = 26;
    localparam int MAG_BITS       = 24;
    localparam int MAGIC_BITS     = 25;
    localparam int DIV_SHIFT      = 29;
    localparam int QUO_BITS       = 20;
    localparam int CORR_BITS      = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int PIPE_STAGES    = 7;

    // ceil(2^29 / 30): exact quotient for magnitudes below 2^24
    localparam logic [MAGIC_BITS-1:0] DIV_MAGIC = 25'd17895698;

    localparam logic [QUO_BITS-1:0]  CORR_POS_LIMIT = 20'd32767;
    localparam logic [QUO_BITS-1:0]  CORR_NEG_LIMIT = 20'd32768;
    localparam logic signed [CORR_BITS-1:0] CORR_MAX = 16'sh7FFF;
    localparam logic signed [CORR_BITS-1:0] CORR_MIN = 16'sh8000;

    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_P = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_I = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_D = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX = 3'd6;

    typedef logic signed [ERR_BITS-1:0]   t_err;
    typedef logic signed [DERR_BITS-1:0]  t_derr;
    typedef logic signed [INTEG_BITS-1:0] t_integ;

    localparam t_err WEIGHT [SENSOR_COUNT] = '{
        -6'sd16, -6'sd8, -6'sd4, -6'sd2, 6'sd2, 6'sd4, 6'sd8, 6'sd16
    };

    typedef struct packed {
        logic [GAIN_BITS-1:0]  gain_p;
        logic [GAIN_BITS-1:0]  gain_d;
        logic [SPEED_BITS-1:0] base_speed;
        logic [SPEED_BITS-1:0] speed_cap;
    } t_pid_cfg;

endpackage

// File: hw/rtl/lfps_lane.sv
// One sensor lane: threshold hysteresis and the sensor's line bit.
`timescale 1ns / 1ps

module lfps_lane #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [SAMPLE_BITS-1:0]        i_raw,
    input  logic [lfps_pkg::THR_BITS-1:0] i_upper,
    input  logic [lfps_pkg::THR_BITS-1:0] i_lower,
    output logic                          o_bit,
    output logic                          o_set
);
    import lfps_pkg::*;

    localparam int CW = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic          r_bit;
    logic          n_bit;
    logic [CW-1:0] w_raw;
    logic [CW-1:0] w_up;
    logic [CW-1:0] w_lo;

    assign w_raw = CW'(i_raw);
    assign w_up  = CW'(i_upper);
    assign w_lo  = CW'(i_lower);

    always_comb begin
        n_bit = r_bit;
        o_set = 1'b0;
        if (w_raw > w_up) begin
            n_bit = 1'b0;
        end else if (w_raw < w_lo) begin
            n_bit = 1'b1;
            o_set = 1'b1;
        end
    end

    assign o_bit = n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_load) begin
            r_bit <= n_bit;
        end
    end

endmodule

// File: hw/rtl/lfps_merge.sv
// Merge of the lane bits into the error, with the integral and previous-error state.
`timescale 1ns / 1ps

module lfps_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [lfps_pkg::SENSOR_COUNT-1:0]   i_bits,
    input  logic [lfps_pkg::SENSOR_COUNT-1:0]   i_set,
    input  logic [lfps_pkg::GAIN_BITS-1:0]      i_gain_i,
    output lfps_pkg::t_err                      o_err,
    output lfps_pkg::t_derr                     o_derr,
    output lfps_pkg::t_integ                    o_integ,
    output logic                                o_seen
);
    import lfps_pkg::*;

    t_err                          r_last_err;
    t_integ                        r_integ;
    t_derr                         r_derr;
    logic                          r_seen;
    t_err                          w_err;
    t_derr                         n_derr;
    logic signed [IPROD_BITS-1:0]  w_iprod;
    logic signed [INTEG_BITS:0]    w_isum;
    t_integ                        n_integ;

    always_comb begin
        w_err = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_bits[i]) begin
                w_err = w_err + WEIGHT[i];
            end
        end
    end

    assign w_iprod = $signed({1'b0, i_gain_i}) * w_err;
    assign w_isum  = (INTEG_BITS+1)'(r_integ) + (INTEG_BITS+1)'(w_iprod);
    assign n_integ = (w_isum[INTEG_BITS] != w_isum[INTEG_BITS-1])
                   ? {w_isum[INTEG_BITS], {(INTEG_BITS-1){~w_isum[INTEG_BITS]}}}
                   : w_isum[INTEG_BITS-1:0];
    assign n_derr  = DERR_BITS'(w_err) - DERR_BITS'(r_last_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_integ    <= '0;
        end else if (i_load) begin
            r_last_err <= w_err;
            r_integ    <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_derr <= n_derr;
            r_seen <= |i_set;
        end
    end

    assign o_err   = r_last_err;
    assign o_derr  = r_derr;
    assign o_integ = r_integ;
    assign o_seen  = r_seen;

endmodule

// File: hw/rtl/lfps_pid.sv
// PID datapath pipeline: gain products, sum, divide by 30, saturation and speed clamps.
`timescale 1ns / 1ps

module lfps_pid (
    input  logic                                 i_clk,
    input  logic [lfps_pkg::PIPE_STAGES-2:0]     i_ld,
    input  lfps_pkg::t_pid_cfg                   i_cfg,
    input  lfps_pkg::t_err                       i_err,
    input  lfps_pkg::t_derr                      i_derr,
    input  lfps_pkg::t_integ                     i_integ,
    input  logic                                 i_seen,
    output logic [lfps_pkg::SPEED_BITS-1:0]      o_left,
    output logic [lfps_pkg::SPEED_BITS-1:0]      o_right,
    output logic signed [lfps_pkg::CORR_BITS-1:0] o_corr,
    output logic                                 o_seen
);
    import lfps_pkg::*;

    localparam int SPD_W = CORR_BITS + 2;
    localparam int QP_W  = MAG_BITS + MAGIC_BITS;

    function automatic logic [SPEED_BITS-1:0] speed_clamp(
        input logic signed [SPD_W-1:0] v,
        input logic [SPEED_BITS-1:0]   mx
    );
        logic [SPEED_BITS-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed(SPD_W'(mx))) begin
            res = mx;
        end else begin
            res = v[SPEED_BITS-1:0];
        end
        return res;
    endfunction

    logic signed [PPROD_BITS-1:0] r_pp;
    logic signed [DPROD_BITS-1:0] r_pd;
    t_integ                       r_ia;
    logic signed [SUM_BITS-1:0]   r_sum;
    logic [MAG_BITS-1:0]          r_mag;
    logic                         r_neg_c;
    logic [QUO_BITS-1:0]          r_quo;
    logic                         r_neg_d;
    logic signed [CORR_BITS-1:0]  r_corr;
    logic [SPEED_BITS-1:0]        r_left;
    logic [SPEED_BITS-1:0]        r_right;
    logic signed [CORR_BITS-1:0]  r_corr_out;
    logic [PIPE_STAGES-2:0]       r_seen;

    logic signed [SUM_BITS-1:0]   w_abs;
    logic [QP_W-1:0]              w_qprod;
    logic signed [CORR_BITS-1:0]  w_corr;
    logic signed [SPD_W-1:0]      w_base;
    logic signed [SPD_W-1:0]      w_lsum;
    logic signed [SPD_W-1:0]      w_rsum;

    assign w_abs   = r_sum[SUM_BITS-1] ? -r_sum : r_sum;
    assign w_qprod = QP_W'(r_mag) * QP_W'(DIV_MAGIC);

    always_comb begin
        if (r_neg_d) begin
            w_corr = (r_quo >= CORR_NEG_LIMIT) ? CORR_MIN
                                               : -$signed(CORR_BITS'(r_quo));
        end else begin
            w_corr = (r_quo > CORR_POS_LIMIT) ? CORR_MAX : $signed(CORR_BITS'(r_quo));
        end
    end

    assign w_base = $signed(SPD_W'(i_cfg.base_speed));
    assign w_lsum = w_base - SPD_W'(r_corr);
    assign w_rsum = w_base + SPD_W'(r_corr);

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_pp      <= $signed({1'b0, i_cfg.gain_p}) * i_err;
            r_pd      <= $signed({1'b0, i_cfg.gain_d}) * i_derr;
            r_ia      <= i_integ;
            r_seen[0] <= i_seen;
        end
        if (i_ld[1]) begin
            r_sum     <= SUM_BITS'(r_pp) + SUM_BITS'(r_pd) + SUM_BITS'(r_ia);
            r_seen[1] <= r_seen[0];
        end
        if (i_ld[2]) begin
            r_neg_c   <= r_sum[SUM_BITS-1];
            r_mag     <= w_abs[MAG_BITS-1:0];
            r_seen[2] <= r_seen[1];
        end
        if (i_ld[3]) begin
            r_neg_d   <= r_neg_c;
            r_quo     <= w_qprod[DIV_SHIFT +: QUO_BITS];
            r_seen[3] <= r_seen[2];
        end
        if (i_ld[4]) begin
            r_corr    <= w_corr;
            r_seen[4] <= r_seen[3];
        end
        if (i_ld[5]) begin
            r_left     <= speed_clamp(w_lsum, i_cfg.speed_cap);
            r_right    <= speed_clamp(w_rsum, i_cfg.speed_cap);
            r_corr_out <= r_corr;
            r_seen[5]  <= r_seen[4];
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_corr  = r_corr_out;
    assign o_seen  = r_seen[PIPE_STAGES-2];

endmodule

// File: hw/rtl/line_follow_pid_steering.sv
// Top level of the line-follow PID steering block: lanes, merge, PID pipeline, config and flow.
//
// Input channel: i_valid / o_stall with one eight-sensor word per accepted word
// (i_ir_raw_0 .. i_ir_raw_7). Output channel: o_valid / i_stall carrying the
// left and right wheel speeds, the signed correction and the line_seen flag.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects
// thresholds, gains, base and max speed; write only while the block is idle.
// Throughput: one word per cycle while the output is not stalled. The hysteresis
// bits, error sum and integral update of a word are registered when it is accepted,
// so the next word can follow at once. From input accept a word then passes the
// product, sum, magnitude, reciprocal multiply, saturate and speed clamp stages to o_valid.
// A stalled output holds its word; each stage keeps taking words while any
// stage ahead of it is empty, and o_stall rises only when all seven are full.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the line
// bits, integral and previous error, and loads the register defaults.
`timescale 1ns / 1ps

module line_follow_pid_steering #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_0,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_1,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_2,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_3,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_4,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_5,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_6,
    input  logic [SAMPLE_BITS-1:0]                 i_ir_raw_7,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [lfps_pkg::SPEED_BITS-1:0]        o_left_speed,
    output logic [lfps_pkg::SPEED_BITS-1:0]        o_right_speed,
    output logic signed [lfps_pkg::CORR_BITS-1:0]  o_steer_correction,
    output logic                                   o_line_seen,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [lfps_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import lfps_pkg::*;

    logic [THR_BITS-1:0]    r_upper;
    logic [THR_BITS-1:0]    r_lower;
    logic [GAIN_BITS-1:0]   r_gain_p;
    logic [GAIN_BITS-1:0]   r_gain_i;
    logic [GAIN_BITS-1:0]   r_gain_d;
    logic [SPEED_BITS-1:0]  r_base;
    logic [SPEED_BITS-1:0]  r_max;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] w_rdy;
    logic [PIPE_STAGES-1:0] w_ld;
    logic [PIPE_STAGES-1:0] w_prev_vld;

    logic [SAMPLE_BITS-1:0]  w_raw [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] w_bits;
    logic [SENSOR_COUNT-1:0] w_set;
    t_err                    w_err;
    t_derr                   w_derr;
    t_integ                  w_integ;
    logic                    w_seen;
    t_pid_cfg                w_pid_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper  <= 10'd512;
            r_lower  <= 10'd250;
            r_gain_p <= 16'd2048;
            r_gain_i <= 16'd51;
            r_gain_d <= 16'd256;
            r_base   <= 12'd640;
            r_max    <= 12'd1280;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_UPPER:  r_upper  <= i_cfg_data[THR_BITS-1:0];
                REG_LOWER:  r_lower  <= i_cfg_data[THR_BITS-1:0];
                REG_GAIN_P: r_gain_p <= i_cfg_data[GAIN_BITS-1:0];
                REG_GAIN_I: r_gain_i <= i_cfg_data[GAIN_BITS-1:0];
                REG_GAIN_D: r_gain_d <= i_cfg_data[GAIN_BITS-1:0];
                REG_BASE:   r_base   <= i_cfg_data[SPEED_BITS-1:0];
                REG_MAX:    r_max    <= i_cfg_data[SPEED_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // advance a stage when it is empty or the stage ahead advances
    assign w_prev_vld = {r_vld[PIPE_STAGES-2:0], i_valid};
    assign w_rdy[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || !i_stall;

    genvar k;
    generate
        for (k = 0; k < PIPE_STAGES - 1; k++) begin : g_rdy
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    endgenerate

    assign w_ld = w_rdy & w_prev_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < PIPE_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= w_prev_vld[s];
                end
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[PIPE_STAGES-1];

    assign w_raw[0] = i_ir_raw_0;
    assign w_raw[1] = i_ir_raw_1;
    assign w_raw[2] = i_ir_raw_2;
    assign w_raw[3] = i_ir_raw_3;
    assign w_raw[4] = i_ir_raw_4;
    assign w_raw[5] = i_ir_raw_5;
    assign w_raw[6] = i_ir_raw_6;
    assign w_raw[7] = i_ir_raw_7;

    genvar g;
    generate
        for (g = 0; g < SENSOR_COUNT; g++) begin : g_lane
            lfps_lane #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_ld[0]),
                .i_raw   (w_raw[g]),
                .i_upper (r_upper),
                .i_lower (r_lower),
                .o_bit   (w_bits[g]),
                .o_set   (w_set[g])
            );
        end
    endgenerate

    lfps_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_ld[0]),
        .i_bits   (w_bits),
        .i_set    (w_set),
        .i_gain_i (r_gain_i),
        .o_err    (w_err),
        .o_derr   (w_derr),
        .o_integ  (w_integ),
        .o_seen   (w_seen)
    );

    assign w_pid_cfg.gain_p     = r_gain_p;
    assign w_pid_cfg.gain_d     = r_gain_d;
    assign w_pid_cfg.base_speed = r_base;
    assign w_pid_cfg.speed_cap  = r_max;

    lfps_pid u_pid (
        .i_clk   (i_clk),
        .i_ld    (w_ld[PIPE_STAGES-1:1]),
        .i_cfg   (w_pid_cfg),
        .i_err   (w_err),
        .i_derr  (w_derr),
        .i_integ (w_integ),
        .i_seen  (w_seen),
        .o_left  (o_left_speed),
        .o_right (o_right_speed),
        .o_corr  (o_steer_correction),
        .o_seen  (o_line_seen)
    );

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_err <= 6'sd30) && (w_err >= -6'sd30))
        else $error("previous error out of weight range");

    a_zero_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_steer_correction == '0)) |-> (o_left_speed == o_right_speed))
        else $error("zero correction with unequal wheel speeds");

endmodule
